@@ rtl/gpa_pkg.sv @@
// Package for the gravity perturbation accumulator: widths, codes, types.
// No dependencies.
package gpa_pkg;

  localparam int MAX_BODIES = 8;
  localparam int IDX_W      = 3;
  localparam int POS_W      = 32;
  localparam int ACC_W      = 48;
  localparam int GM_W       = 48;
  localparam int NACT_W     = 4;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_SRC  = 2'd1,
    CMD_EMIT = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_GM  = 1'b0,
    CFG_ACT = 1'b1
  } cfg_idx_t;

  // one queued item from the front end to the back end
  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_W-1:0]         idx;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  pz;
    logic signed [ACC_W-1:0]  ax;
    logic signed [ACC_W-1:0]  ay;
    logic signed [ACC_W-1:0]  az;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DEN,
    ST_DEN_HI,
    ST_NUM,
    ST_NUM_HI,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } st_t;

endpackage

@@ rtl/gravity_perturbation_accumulator.sv @@
// Top level of the gravity perturbation accumulator; config registers and wiring.
// Depends on gpa_pkg, gpa_front, gpa_queue, gpa_back.
//
//  port group  direction  handshake
//  in_*        input      in_valid / in_stall
//  out_*       output     out_valid / out_stall
//  cfg_*       input      cfg_wr_en, no wait
//
// A source item leaves the queue, then each served body at zero distance is flagged and
// skipped; any other goes through the normalising shifts, the square root, split products
// and three shift-subtract divisions that stop at their step count or at the quotient cap.
// Loads are written from the queue head; emits give one body per cycle while out_stall is
// low. Reset is synchronous and clears control and flags; the queue holds two items so
// input is taken while busy.
module gravity_perturbation_accumulator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [gpa_pkg::GM_W-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_command,
  input  logic [gpa_pkg::IDX_W-1:0]        in_body_index,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_z,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_x,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_y,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gpa_pkg::IDX_W-1:0]        out_out_index,
  output logic signed [gpa_pkg::ACC_W-1:0] out_acc_x,
  output logic signed [gpa_pkg::ACC_W-1:0] out_acc_y,
  output logic signed [gpa_pkg::ACC_W-1:0] out_acc_z,
  output logic                             out_flagged,
  output logic                             out_last
);

  logic [gpa_pkg::GM_W-1:0]   gm_r;
  logic [gpa_pkg::NACT_W-1:0] act_r;
  logic           q_full, q_empty, q_wr, q_rd;
  gpa_pkg::item_t q_wi, q_ri;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r  <= gpa_pkg::GM_W'(1);
      act_r <= gpa_pkg::NACT_W'(1);
    end else if (cfg_wr_en) begin
      if (gpa_pkg::cfg_idx_t'(cfg_index) == gpa_pkg::CFG_GM) gm_r <= cfg_data;
      else act_r <= cfg_data[gpa_pkg::NACT_W-1:0];
    end
  end

  gpa_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_body_index,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_start_acc_x, .in_start_acc_y,
    .in_start_acc_z, .q_full, .q_wr, .q_item(q_wi)
  );

  gpa_queue u_queue (
    .clk, .rst_n, .wr_en(q_wr), .wr_item(q_wi), .full(q_full),
    .rd_en(q_rd), .rd_item(q_ri), .empty(q_empty)
  );

  gpa_back u_back (
    .clk, .rst_n, .gm(gm_r), .nact(act_r), .q_empty, .q_item(q_ri), .q_rd,
    .out_valid, .out_stall, .out_out_index, .out_acc_x, .out_acc_y,
    .out_acc_z, .out_flagged, .out_last
  );

endmodule

@@ rtl/gpa_queue.sv @@
// Two-entry item queue between front end and back end.
// Depends on gpa_pkg.
module gpa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  gpa_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd_en,
  output gpa_pkg::item_t rd_item,
  output logic           empty
);

  gpa_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !rd_en)
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

@@ rtl/gpa_front.sv @@
// Front end: takes input items, drops unused codes, pushes to the queue.
// Depends on gpa_pkg.
module gpa_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [gpa_pkg::IDX_W-1:0]      in_body_index,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_z,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_x,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_y,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_z,
  input  logic                           q_full,
  output logic                           q_wr,
  output gpa_pkg::item_t                 q_item
);

  logic acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  // code three has no effect, so it never enters the queue
  assign q_wr     = acc && (gpa_pkg::cmd_t'(in_command) != gpa_pkg::CMD_NONE);

  always_comb begin
    q_item.cmd = gpa_pkg::cmd_t'(in_command);
    q_item.idx = in_body_index;
    q_item.px  = in_pos_x;
    q_item.py  = in_pos_y;
    q_item.pz  = in_pos_z;
    q_item.ax  = in_start_acc_x;
    q_item.ay  = in_start_acc_y;
    q_item.az  = in_start_acc_z;
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_wr |-> acc)
    else $error("push without accept");
  assert property (@(posedge clk) disable iff (!rst_n)
                   q_wr |-> q_item.cmd != gpa_pkg::CMD_NONE)
    else $error("unused code queued");
  assert property (@(posedge clk) disable iff (!rst_n) q_full |-> in_stall)
    else $error("no stall when full");

endmodule

@@ rtl/gpa_back.sv @@
// Back end: body store, per-pair arithmetic sequencer, emit and output register.
// Depends on gpa_pkg.
module gpa_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [gpa_pkg::GM_W-1:0]         gm,
  input  logic [gpa_pkg::NACT_W-1:0]       nact,
  input  logic                             q_empty,
  input  gpa_pkg::item_t                   q_item,
  output logic                             q_rd,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gpa_pkg::IDX_W-1:0]        out_out_index,
  output logic signed [gpa_pkg::ACC_W-1:0] out_acc_x,
  output logic signed [gpa_pkg::ACC_W-1:0] out_acc_y,
  output logic signed [gpa_pkg::ACC_W-1:0] out_acc_z,
  output logic                             out_flagged,
  output logic                             out_last
);

  localparam int NB = gpa_pkg::MAX_BODIES;
  localparam int IW = gpa_pkg::IDX_W;
  localparam int AW = gpa_pkg::ACC_W;
  localparam int PW = gpa_pkg::POS_W;
  localparam logic signed [AW:0] AMAX = {2'b00, {(AW-1){1'b1}}};
  localparam logic signed [AW:0] AMIN = {2'b11, {(AW-1){1'b0}}};

  logic signed [PW-1:0] bx_r [NB];
  logic signed [PW-1:0] by_r [NB];
  logic signed [PW-1:0] bz_r [NB];
  logic signed [AW-1:0] sx_r [NB];
  logic signed [AW-1:0] sy_r [NB];
  logic signed [AW-1:0] sz_r [NB];
  logic [NB-1:0]        flag_r;

  gpa_pkg::st_t st_r, st_nxt;
  gpa_pkg::item_t it_r;
  logic [IW:0]   slot_r;      // one wider: counts to the served total
  logic [IW:0]   n_r;
  logic signed [PW:0] d_r [3];
  logic [32:0]   u_r [3];
  logic signed [6:0] k_r;
  logic [63:0]   sq_r, rem_r, bit_r, res_r;
  logic [95:0]   den_r;
  logic [1:0]    ax_r;        // axis under division
  logic [96:0]   num_r;
  logic [48:0]   q_r;
  logic [6:0]    dcnt_r;
  logic [48:0]   qv_r [3];
  logic          ov_r;        // output register full
  logic [IW-1:0] oi_r;
  logic signed [AW-1:0] ox_r, oy_r, oz_r;
  logic          of_r, ol_r;

  logic [IW-1:0] s;
  logic [32:0]   m;
  logic          out_free;
  logic [6:0]    dlen;

  assign s        = slot_r[IW-1:0];
  assign out_free = !ov_r || !out_stall;
  assign m = (u_r[0] > u_r[1]) ? ((u_r[0] > u_r[2]) ? u_r[0] : u_r[2])
                               : ((u_r[1] > u_r[2]) ? u_r[1] : u_r[2]);
  assign dlen = 7'(7'sd46 - (k_r <<< 1));

  assign out_valid     = ov_r;
  assign out_out_index = oi_r;
  assign out_acc_x     = ox_r;
  assign out_acc_y     = oy_r;
  assign out_acc_z     = oz_r;
  assign out_flagged   = of_r;
  assign out_last      = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= gpa_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    q_rd   = 1'b0;
    case (st_r)
      gpa_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          case (q_item.cmd)
            gpa_pkg::CMD_SRC:  st_nxt = (n_r == '0) ? gpa_pkg::ST_IDLE : gpa_pkg::ST_DIFF;
            gpa_pkg::CMD_EMIT: st_nxt = (n_r == '0) ? gpa_pkg::ST_IDLE : gpa_pkg::ST_EMIT;
            default:           st_nxt = gpa_pkg::ST_IDLE;
          endcase
        end
      end
      gpa_pkg::ST_DIFF:  st_nxt = gpa_pkg::ST_NORM;
      gpa_pkg::ST_NORM: begin
        if (m == '0) st_nxt = (slot_r + 1'b1 >= n_r) ? gpa_pkg::ST_IDLE : gpa_pkg::ST_DIFF;
        else if (m[32:30] == 3'b001) st_nxt = gpa_pkg::ST_SQ;
      end
      gpa_pkg::ST_SQ:     st_nxt = gpa_pkg::ST_SQRT;
      gpa_pkg::ST_SQRT:   if (bit_r == '0) st_nxt = gpa_pkg::ST_DEN;
      gpa_pkg::ST_DEN:    st_nxt = gpa_pkg::ST_DEN_HI;
      gpa_pkg::ST_DEN_HI: st_nxt = gpa_pkg::ST_NUM;
      gpa_pkg::ST_NUM:    st_nxt = gpa_pkg::ST_NUM_HI;
      gpa_pkg::ST_NUM_HI: st_nxt = gpa_pkg::ST_DIV;
      gpa_pkg::ST_DIV: begin
        if (dcnt_r == dlen || q_r[48])
          st_nxt = (ax_r == 2'd2) ? gpa_pkg::ST_APPLY : gpa_pkg::ST_NUM;
      end
      gpa_pkg::ST_APPLY:
        st_nxt = (slot_r + 1'b1 >= n_r) ? gpa_pkg::ST_IDLE : gpa_pkg::ST_DIFF;
      gpa_pkg::ST_EMIT:
        if (out_free && slot_r + 1'b1 >= n_r) st_nxt = gpa_pkg::ST_IDLE;
      default: st_nxt = gpa_pkg::ST_IDLE;
    endcase
  end

  function automatic logic signed [AW-1:0] upd(input logic signed [AW-1:0] a,
      input logic signed [PW:0] d, input logic [48:0] q, output logic sat);
    logic signed [AW+1:0] v;
    v = {{2{a[AW-1]}}, a};
    if (d > 0)      v = v - $signed({1'b0, q});
    else if (d < 0) v = v + $signed({1'b0, q});
    sat = 1'b0;
    if (v > $signed({AMAX[AW], AMAX})) begin v = {AMAX[AW], AMAX}; sat = 1'b1; end
    if (v < $signed({AMIN[AW], AMIN})) begin v = {AMIN[AW], AMIN}; sat = 1'b1; end
    return v[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    logic sx, sy, sz;
    logic [63:0] t;
    logic [96:0] sh;
    if (!rst_n) begin
      flag_r <= '0;
      ov_r   <= 1'b0;
      slot_r <= '0;
      n_r    <= '0;
    end else begin
      if (out_free && st_r != gpa_pkg::ST_EMIT) ov_r <= 1'b0;
      case (st_r)
        gpa_pkg::ST_IDLE: begin
          slot_r <= '0;
          n_r    <= (nact > 4'(NB)) ? (IW+1)'(NB) : (IW+1)'(nact);
          if (!q_empty) begin
            it_r <= q_item;
            if (q_item.cmd == gpa_pkg::CMD_LOAD) begin
              bx_r[q_item.idx] <= q_item.px;
              by_r[q_item.idx] <= q_item.py;
              bz_r[q_item.idx] <= q_item.pz;
              sx_r[q_item.idx] <= q_item.ax;
              sy_r[q_item.idx] <= q_item.ay;
              sz_r[q_item.idx] <= q_item.az;
              flag_r[q_item.idx] <= 1'b0;
            end
          end
        end
        gpa_pkg::ST_DIFF: begin
          d_r[0] <= (PW+1)'(bx_r[s]) - (PW+1)'(it_r.px);
          d_r[1] <= (PW+1)'(by_r[s]) - (PW+1)'(it_r.py);
          d_r[2] <= (PW+1)'(bz_r[s]) - (PW+1)'(it_r.pz);
          u_r[0] <= 33'(bx_r[s] > it_r.px ? {bx_r[s][PW-1], bx_r[s]} - {it_r.px[PW-1], it_r.px}
                                          : {it_r.px[PW-1], it_r.px} - {bx_r[s][PW-1], bx_r[s]});
          u_r[1] <= 33'(by_r[s] > it_r.py ? {by_r[s][PW-1], by_r[s]} - {it_r.py[PW-1], it_r.py}
                                          : {it_r.py[PW-1], it_r.py} - {by_r[s][PW-1], by_r[s]});
          u_r[2] <= 33'(bz_r[s] > it_r.pz ? {bz_r[s][PW-1], bz_r[s]} - {it_r.pz[PW-1], it_r.pz}
                                          : {it_r.pz[PW-1], it_r.pz} - {bz_r[s][PW-1], bz_r[s]});
          k_r <= '0;
        end
        gpa_pkg::ST_NORM: begin
          // one shift a cycle until the largest lies in [2^30, 2^31)
          if (m == '0) begin
            flag_r[s] <= 1'b1;
            slot_r <= slot_r + 1'b1;
          end else if (m[32:31] != 2'b00) begin
            for (int c = 0; c < 3; c++) u_r[c] <= u_r[c] >> 1;
            k_r <= k_r + 7'sd1;
          end else if (!m[30]) begin
            for (int c = 0; c < 3; c++) u_r[c] <= u_r[c] << 1;
            k_r <= k_r - 7'sd1;
          end
        end
        gpa_pkg::ST_SQ: begin
          sq_r  <= 64'(u_r[0][30:0] * u_r[0][30:0]) + 64'(u_r[1][30:0] * u_r[1][30:0])
                 + 64'(u_r[2][30:0] * u_r[2][30:0]);
          bit_r <= 64'd1 << 62;
          res_r <= '0;
        end
        gpa_pkg::ST_SQRT: begin
          if (bit_r != '0) begin
            t = (res_r == '0 && bit_r == (64'd1 << 62)) ? sq_r : rem_r;
            if (t >= res_r + bit_r) begin
              rem_r <= t - (res_r + bit_r);
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              rem_r <= t;
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
          ax_r  <= 2'd0;
        end
        gpa_pkg::ST_DEN: begin
          // root is below 2^32: two 32 by 32 products
          den_r <= 96'(64'(sq_r[31:0]) * 64'(res_r[31:0]));
          rem_r <= '0;
        end
        gpa_pkg::ST_DEN_HI: begin
          den_r <= den_r + (96'(64'(sq_r[63:32]) * 64'(res_r[31:0])) << 32);
        end
        gpa_pkg::ST_NUM: begin
          num_r  <= 97'(55'(gm[23:0]) * 55'(u_r[ax_r][30:0]));
          q_r    <= '0;
          dcnt_r <= '0;
        end
        gpa_pkg::ST_NUM_HI: begin
          num_r  <= num_r + (97'(55'(gm[47:24]) * 55'(u_r[ax_r][30:0])) << 24);
        end
        gpa_pkg::ST_DIV: begin
          sh = num_r << 1;
          if (dcnt_r == dlen || q_r[48]) begin
            qv_r[ax_r] <= q_r[48] ? 49'h1_0000_0000_0000 : q_r;
            ax_r <= ax_r + 2'd1;
          end else begin
            dcnt_r <= dcnt_r + 7'd1;
            if (sh >= {1'b0, den_r}) begin
              num_r <= sh - {1'b0, den_r};
              q_r   <= {q_r[47:0], 1'b1};
            end else begin
              num_r <= sh;
              q_r   <= {q_r[47:0], 1'b0};
            end
          end
        end
        gpa_pkg::ST_APPLY: begin
          sx_r[s] <= upd(sx_r[s], d_r[0], qv_r[0], sx);
          sy_r[s] <= upd(sy_r[s], d_r[1], qv_r[1], sy);
          sz_r[s] <= upd(sz_r[s], d_r[2], qv_r[2], sz);
          if (sx || sy || sz) flag_r[s] <= 1'b1;
          slot_r <= slot_r + 1'b1;
        end
        gpa_pkg::ST_EMIT: begin
          if (out_free) begin
            ov_r <= 1'b1;
            oi_r <= s;
            ox_r <= sx_r[s];
            oy_r <= sy_r[s];
            oz_r <= sz_r[s];
            of_r <= flag_r[s];
            ol_r <= (slot_r + 1'b1 >= n_r);
            slot_r <= slot_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
                   ov_r && out_stall |=> ov_r && $stable(oi_r))
    else $error("output changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
                   st_r != gpa_pkg::ST_IDLE |-> !q_rd)
    else $error("queue read while busy");
  assert property (@(posedge clk) disable iff (!rst_n) slot_r <= n_r)
    else $error("slot beyond served count");

endmodule

@@ bench/gpa_checker.sv @@
// Checker for the gravity perturbation accumulator: watches config, input and result ports,
// predicts each emitted item and compares it field by field. Depends on gpa_pkg.
module gpa_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [gpa_pkg::GM_W-1:0]         cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_command,
  input  logic [gpa_pkg::IDX_W-1:0]        in_body_index,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [gpa_pkg::POS_W-1:0] in_pos_z,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_x,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_y,
  input  logic signed [gpa_pkg::ACC_W-1:0] in_start_acc_z,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [gpa_pkg::IDX_W-1:0]        out_out_index,
  input  logic signed [gpa_pkg::ACC_W-1:0] out_acc_x,
  input  logic signed [gpa_pkg::ACC_W-1:0] out_acc_y,
  input  logic signed [gpa_pkg::ACC_W-1:0] out_acc_z,
  input  logic                             out_flagged,
  input  logic                             out_last,
  output int                               failures,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gpa_pkg::*;

  localparam logic signed [63:0] ACC_HI = 64'sd140737488355327;
  localparam logic signed [63:0] ACC_LO = -64'sd140737488355328;
  localparam logic [63:0]        Q_CAP  = 64'd1 << 48;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    logic                    flag;
    logic                    last;
  } body_report_t;

  body_report_t       reports_due[$];
  logic [GM_W-1:0]    gm_reg;
  logic [NACT_W-1:0]  active_reg;
  logic signed [63:0] bx[MAX_BODIES], by[MAX_BODIES], bz[MAX_BODIES];
  logic signed [63:0] ax_sum[MAX_BODIES], ay_sum[MAX_BODIES], az_sum[MAX_BODIES];
  logic               flags[MAX_BODIES];

  assign pending = reports_due.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor(num * 2^e / den) bit by bit, stopping at the cap
  function automatic logic [63:0] scaled_quot(logic [127:0] num, logic [127:0] den, int e);
    logic [63:0] q;
    q = 0;
    for (int i = 0; i < e; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q[0] = 1'b1;
      end
      if (q >= Q_CAP) return Q_CAP;
    end
    return q;
  endfunction

  function automatic logic signed [63:0] nudge(logic signed [63:0] acc, logic signed [63:0] d,
                                               logic [63:0] q, int s);
    logic signed [63:0] v;
    v = acc;
    if (d > 0) v = v - $signed(q);
    else if (d < 0) v = v + $signed(q);
    if (v > ACC_HI) begin
      v = ACC_HI;
      flags[s] = 1'b1;
    end
    if (v < ACC_LO) begin
      v = ACC_LO;
      flags[s] = 1'b1;
    end
    return v;
  endfunction

  task automatic pull_body(int s, logic signed [63:0] px, logic signed [63:0] py,
                           logic signed [63:0] pz);
    logic signed [63:0] d[3];
    logic [63:0]        u[3];
    logic [63:0]        m, sq, r;
    logic [63:0]        q[3];
    logic [127:0]       den;
    int                 k;
    d[0] = bx[s] - px;
    d[1] = by[s] - py;
    d[2] = bz[s] - pz;
    for (int c = 0; c < 3; c++) u[c] = d[c] < 0 ? -d[c] : d[c];
    m = u[0];
    if (u[1] > m) m = u[1];
    if (u[2] > m) m = u[2];
    if (m == 0) begin
      flags[s] = 1'b1;
      return;
    end
    k = 0;
    while (m >= (64'd1 << 31)) begin m = m >> 1; k++; end
    while (m < (64'd1 << 30)) begin m = m << 1; k--; end
    for (int c = 0; c < 3; c++) u[c] = k >= 0 ? (u[c] >> k) : (u[c] << (-k));
    sq = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    r = int_sqrt(sq);
    den = {64'd0, sq} * {64'd0, r};
    for (int c = 0; c < 3; c++)
      q[c] = scaled_quot({80'd0, gm_reg} * {64'd0, u[c]}, den, 46 - 2 * k);
    ax_sum[s] = nudge(ax_sum[s], d[0], q[0], s);
    ay_sum[s] = nudge(ay_sum[s], d[1], q[1], s);
    az_sum[s] = nudge(az_sum[s], d[2], q[2], s);
  endtask

  always @(posedge clk) begin
    int n;
    body_report_t rep;
    if (!rst_n) begin
      gm_reg = 1;
      active_reg = 1;
      for (int i = 0; i < MAX_BODIES; i++) flags[i] = 1'b0;
      reports_due.delete();
      failures <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_GM) gm_reg = cfg_data;
        else active_reg = cfg_data[NACT_W-1:0];
      end
      n = active_reg > MAX_BODIES ? MAX_BODIES : active_reg;
      if (in_valid && !in_stall) begin
        case (cmd_t'(in_command))
          CMD_LOAD: begin
            bx[in_body_index] = in_pos_x;
            by[in_body_index] = in_pos_y;
            bz[in_body_index] = in_pos_z;
            ax_sum[in_body_index] = in_start_acc_x;
            ay_sum[in_body_index] = in_start_acc_y;
            az_sum[in_body_index] = in_start_acc_z;
            flags[in_body_index] = 1'b0;
          end
          CMD_SRC: begin
            for (int i = 0; i < n; i++) pull_body(i, in_pos_x, in_pos_y, in_pos_z);
          end
          CMD_EMIT: begin
            for (int i = 0; i < n; i++) begin
              rep.idx  = i[IDX_W-1:0];
              rep.ax   = ax_sum[i][ACC_W-1:0];
              rep.ay   = ay_sum[i][ACC_W-1:0];
              rep.az   = az_sum[i][ACC_W-1:0];
              rep.flag = flags[i];
              rep.last = (i + 1 == n);
              reports_due.push_back(rep);
            end
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected result idx %0d acc %h %h %h", $realtime, out_out_index,
                   out_acc_x, out_acc_y, out_acc_z);
          failures <= failures + 1;
        end else begin
          rep = reports_due.pop_front();
          if (out_out_index !== rep.idx || out_acc_x !== rep.ax || out_acc_y !== rep.ay ||
              out_acc_z !== rep.az || out_flagged !== rep.flag || out_last !== rep.last) begin
            $display("%0t: mismatch expected idx %0d acc %h %h %h flag %b last %b",
                     $realtime, rep.idx, rep.ax, rep.ay, rep.az, rep.flag, rep.last);
            $display("%0t:            actual idx %0d acc %h %h %h flag %b last %b",
                     $realtime, out_out_index, out_acc_x, out_acc_y, out_acc_z,
                     out_flagged, out_last);
            failures <= failures + 1;
          end
        end
      end
    end
  end

endmodule

@@ bench/gravity_perturbation_accumulator_test.sv @@
// Top of the accumulator bench: clock, reset, config writes, item stimulus and the verdict.
// Depends on gpa_pkg, gravity_perturbation_accumulator and gpa_checker.
module gravity_perturbation_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gpa_pkg::*;

  localparam int STALL_LIMIT = 60000;
  // covers two queued sources and one in progress, eight far-apart bodies each
  localparam int DRAIN_WAIT  = 12000;

  logic                    clk, rst_n;
  logic                    cfg_wr_en, cfg_index;
  logic [GM_W-1:0]         cfg_data;
  logic                    in_valid, in_stall;
  logic [1:0]              in_command;
  logic [IDX_W-1:0]        in_body_index;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [ACC_W-1:0] in_start_acc_x, in_start_acc_y, in_start_acc_z;
  logic                    out_valid, out_stall;
  logic [IDX_W-1:0]        out_out_index;
  logic signed [ACC_W-1:0] out_acc_x, out_acc_y, out_acc_z;
  logic                    out_flagged, out_last;
  int                      failures, pending;
  int                      send_idle, recv_idle, quiet;
  logic signed [POS_W-1:0] home_x[MAX_BODIES], home_y[MAX_BODIES], home_z[MAX_BODIES];

  gravity_perturbation_accumulator u_dut (.*);
  gpa_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [ACC_W-1:0] rand_acc();
    return ACC_W'({$urandom(), $urandom()});
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [GM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(cmd_t cmd, int idx, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                      logic [POS_W-1:0] pz, logic [ACC_W-1:0] ax, logic [ACC_W-1:0] ay,
                      logic [ACC_W-1:0] az);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_body_index  <= idx[IDX_W-1:0];
    in_pos_x       <= px;
    in_pos_y       <= py;
    in_pos_z       <= pz;
    in_start_acc_x <= ax;
    in_start_acc_y <= ay;
    in_start_acc_z <= az;
    if (cmd == CMD_LOAD) begin
      home_x[idx] = px;
      home_y[idx] = py;
      home_z[idx] = pz;
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_rand(int idx);
    send(CMD_LOAD, idx, $urandom(), $urandom(), $urandom(), rand_acc(), rand_acc(), rand_acc());
  endtask

  // planetesimal close to (or on) a stored body, so zero distance and clamping come up
  task automatic source_near(int idx, int spread);
    send(CMD_SRC, 0, home_x[idx] + $urandom_range(2 * spread) - spread,
         home_y[idx] + $urandom_range(2 * spread) - spread,
         home_z[idx] + $urandom_range(2 * spread) - spread, rand_acc(), rand_acc(), rand_acc());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [GM_W-1:0] gm_val;
    int              nact, pick;
    rst_n = 0; cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_command = 0; in_body_index = 0;
    in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    in_start_acc_x = 0; in_start_acc_y = 0; in_start_acc_z = 0;
    send_idle = 14; recv_idle = 84;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, zero distance, clamping, flag clear on load
    write_reg(CFG_GM, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_ACT, GM_W'(8));
    send(CMD_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 48'h7FFF_FFFF_FFFF,
         48'h8000_0000_0000, 48'h0);
    send(CMD_LOAD, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 48'h8000_0000_0000,
         48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    for (int i = 2; i < MAX_BODIES; i++) load_rand(i);
    send(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_SRC, 0, home_x[2], home_y[2], home_z[2], 0, 0, 0);
    source_near(3, 4);
    send(CMD_SRC, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
    send(CMD_NONE, 7, $urandom(), $urandom(), $urandom(), rand_acc(), rand_acc(), rand_acc());
    send(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0);
    load_rand(2);
    send(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle = 84; recv_idle = 14; end
      if (ph == 8) begin send_idle = 0;  recv_idle = 0;  end
      case (ph % 4)
        0: gm_val = 1;
        1: gm_val = 48'hFFFF_FFFF_FFFF;
        2: gm_val = GM_W'({$urandom(), $urandom()});
        default: gm_val = GM_W'($urandom_range(1, 1 << 20)) << $urandom_range(0, 27);
      endcase
      case (ph)
        0, 5, 10: nact = 8;
        1, 6:     nact = 1;
        3:        nact = 0;
        7:        nact = 15;
        default:  nact = $urandom_range(1, 8);
      endcase
      write_reg(CFG_GM, gm_val);
      write_reg(CFG_ACT, GM_W'(nact));
      for (int it = 0; it < 35; it++) begin
        pick = $urandom_range(99);
        if (pick < 15) load_rand($urandom_range(0, MAX_BODIES - 1));
        else if (pick < 25) source_near($urandom_range(0, MAX_BODIES - 1), 1 << $urandom_range(0, 24));
        else if (pick < 30) source_near($urandom_range(0, MAX_BODIES - 1), 0);
        else if (pick < 50)
          send(CMD_SRC, $urandom_range(0, 7), $urandom(), $urandom(), $urandom(),
               rand_acc(), rand_acc(), rand_acc());
        else if (pick < 95)
          send(CMD_EMIT, $urandom_range(0, 7), $urandom(), $urandom(), $urandom(),
               rand_acc(), rand_acc(), rand_acc());
        else
          send(CMD_NONE, $urandom_range(0, 7), $urandom(), $urandom(), $urandom(),
               rand_acc(), rand_acc(), rand_acc());
      end
      settle();
    end

    if (failures == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
